### src/psbf_pkg.sv
// psbf_pkg: shared constants, types and codes of the PAwR subevent buffer.
// Used by psbf_oreg, psbf_engine and the top level; no dependencies.
`timescale 1ns / 1ps

package psbf_pkg;

    localparam int HANDLES       = 16;
    localparam int SUBEVENTS     = 64;
    localparam int CHUNK_ENTRIES = 15;
    localparam int CHUNK_BYTES   = 253;
    localparam int MAX_RESULTS   = 64;

    localparam int DEPTH  = HANDLES * SUBEVENTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] LEN_MAX        = 8'hF9;
    localparam logic [7:0] ENTRY_OVERHEAD = 8'd4;

    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_BAD   = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic       valid;
        logic [7:0] slot_first;
        logic [7:0] slot_total;
        logic [7:0] length;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic       status;
        logic [6:0] chunk_first;
        logic [6:0] chunk_final;
        logic [3:0] chunk_entries;
        logic [7:0] chunk_bytes;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    // decoded input word
    typedef struct packed {
        logic       is_write;
        logic       bad;
        logic [6:0] start;
        logic [7:0] wend;
        t_addr      base;
        t_addr      wr_addr;
        t_entry     wr_entry;
    } t_cmd;

endpackage

### src/psbf_if.sv
// Valid/ready channel interfaces for the subevent buffer input and result words.
// No dependencies.
`timescale 1ns / 1ps

interface psbf_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] handle;
    logic [6:0] subevent_index;
    logic [7:0] window_count;
    logic [7:0] slot_first;
    logic [7:0] slot_total;
    logic [7:0] payload_length;

    modport source (
        output valid, mode, handle, subevent_index, window_count,
               slot_first, slot_total, payload_length,
        input  ready
    );
    modport sink (
        input  valid, mode, handle, subevent_index, window_count,
               slot_first, slot_total, payload_length,
        output ready
    );
endinterface

interface psbf_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [6:0] chunk_first;
    logic [6:0] chunk_final;
    logic [3:0] chunk_entries;
    logic [7:0] chunk_bytes;
    logic       last;

    modport source (
        output valid, status, chunk_first, chunk_final, chunk_entries,
               chunk_bytes, last,
        input  ready
    );
    modport sink (
        input  valid, status, chunk_first, chunk_final, chunk_entries,
               chunk_bytes, last,
        output ready
    );
endinterface

### src/psbf_ram.sv
// psbf_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module psbf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 25,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/psbf_oreg.sv
// psbf_oreg: result output register, parts the engine from the result sink.
// Depends on psbf_pkg and psbf_out_if.
`timescale 1ns / 1ps

module psbf_oreg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  psbf_pkg::t_push i_push,
    output logic            o_free,
    psbf_out_if.source      o_out
);

    logic              r_vld;
    psbf_pkg::t_result r_res;

    assign o_free = !r_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_res <= i_push.res;
        end
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push.valid) begin
            r_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_vld <= 1'b0;
        end
    end

    assign o_out.valid         = r_vld;
    assign o_out.status        = r_res.status;
    assign o_out.chunk_first   = r_res.chunk_first;
    assign o_out.chunk_final   = r_res.chunk_final;
    assign o_out.chunk_entries = r_res.chunk_entries;
    assign o_out.chunk_bytes   = r_res.chunk_bytes;
    assign o_out.last          = r_res.last;

endmodule

### src/psbf_engine.sv
// psbf_engine: clearing pass, entry writes and window scan with chunk packing.
// Depends on psbf_pkg; drives the entry RAM and the output register.
`timescale 1ns / 1ps

module psbf_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_take,
    input  psbf_pkg::t_cmd                  i_cmd,
    output logic                            o_ready,
    input  logic                            i_out_free,
    output psbf_pkg::t_push                 o_push,
    output logic                            o_ram_we,
    output psbf_pkg::t_addr                 o_ram_waddr,
    output logic [psbf_pkg::ENTRY_W-1:0]    o_ram_wdata,
    output psbf_pkg::t_addr                 o_ram_raddr,
    input  logic [psbf_pkg::ENTRY_W-1:0]    i_ram_rdata
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_DONE} t_state;

    t_state            r_state, n_state;
    psbf_pkg::t_addr   r_clr, n_clr;
    psbf_pkg::t_addr   r_base, n_base;
    logic [6:0]        r_start, n_start;
    logic [7:0]        r_end, n_end;
    logic [7:0]        r_ptr, n_ptr;
    logic              r_q_vld, n_q_vld;
    logic [6:0]        r_q_s, n_q_s;
    logic [3:0]        r_ents, n_ents;
    logic [7:0]        r_bytes, n_bytes;
    logic [6:0]        r_first, n_first;
    logic [6:0]        r_final, n_final;
    psbf_pkg::t_cnt    r_n, n_n;
    logic              r_h_vld, n_h_vld;
    psbf_pkg::t_result r_h, n_h;

    psbf_pkg::t_entry  entry;
    logic [8:0]        cost;
    logic [8:0]        sum;
    logic              ovf;
    logic [3:0]        ents_a;
    logic [7:0]        bytes_a;
    logic [6:0]        first_a;
    psbf_pkg::t_cnt    n_inc;
    psbf_pkg::t_result cur_chunk;
    psbf_pkg::t_result add_chunk;

    assign entry   = psbf_pkg::t_entry'(i_ram_rdata);
    assign cost    = {1'b0, psbf_pkg::ENTRY_OVERHEAD} + {1'b0, entry.length};
    assign sum     = {1'b0, r_bytes} + cost;
    assign ovf     = (r_ents != 4'd0) && (int'(sum) > psbf_pkg::CHUNK_BYTES);
    assign ents_a  = ovf ? 4'd1 : (r_ents + 4'd1);
    assign bytes_a = ovf ? cost[7:0] : sum[7:0];
    assign first_a = (ovf || r_ents == 4'd0) ? r_q_s : r_first;
    assign n_inc   = r_n + psbf_pkg::t_cnt'(1);

    assign cur_chunk = '{status: psbf_pkg::STATUS_OK, chunk_first: r_first,
                         chunk_final: r_final, chunk_entries: r_ents,
                         chunk_bytes: r_bytes, last: 1'b0};
    assign add_chunk = '{status: psbf_pkg::STATUS_OK, chunk_first: first_a,
                         chunk_final: r_q_s, chunk_entries: ents_a,
                         chunk_bytes: bytes_a, last: 1'b0};

    always_comb begin
        logic emit;
        logic full;
        logic stall;
        logic stop;
        psbf_pkg::t_result chunk;

        n_state = r_state;
        n_clr   = r_clr;
        n_base  = r_base;
        n_start = r_start;
        n_end   = r_end;
        n_ptr   = r_ptr;
        n_q_vld = r_q_vld;
        n_q_s   = r_q_s;
        n_ents  = r_ents;
        n_bytes = r_bytes;
        n_first = r_first;
        n_final = r_final;
        n_n     = r_n;
        n_h_vld = r_h_vld;
        n_h     = r_h;

        emit  = 1'b0;
        full  = 1'b0;
        stall = 1'b0;
        stop  = 1'b0;
        chunk = add_chunk;

        o_ready     = 1'b0;
        o_push      = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_clr;
        o_ram_wdata = '0;
        o_ram_raddr = r_base + psbf_pkg::t_addr'(r_ptr);

        unique case (r_state)
            S_CLEAR: begin
                o_ram_we = 1'b1;
                n_clr    = r_clr + psbf_pkg::t_addr'(1);
                if (r_clr == psbf_pkg::t_addr'(psbf_pkg::DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_ready = 1'b1;
                if (i_take) begin
                    n_start = i_cmd.start;
                    n_end   = i_cmd.wend;
                    if (i_cmd.is_write || i_cmd.bad) begin
                        if (i_cmd.is_write && !i_cmd.bad) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = i_cmd.wr_addr;
                            o_ram_wdata = i_cmd.wr_entry;
                        end
                        n_h = '{status: i_cmd.bad, chunk_first: i_cmd.start,
                                chunk_final: i_cmd.start, chunk_entries: 4'd0,
                                chunk_bytes: 8'd0, last: 1'b0};
                        n_h_vld = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_base  = i_cmd.base;
                        n_ptr   = {1'b0, i_cmd.start};
                        n_q_vld = 1'b0;
                        n_ents  = 4'd0;
                        n_bytes = 8'd0;
                        n_n     = '0;
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (r_q_vld || r_ptr < r_end) begin
                    if (r_q_vld && entry.valid) begin
                        full  = int'(ents_a) == psbf_pkg::CHUNK_ENTRIES;
                        emit  = ovf || full;
                        chunk = ovf ? cur_chunk : add_chunk;
                        stall = emit && r_h_vld && !i_out_free;
                        stop  = emit && (int'(n_inc) == psbf_pkg::MAX_RESULTS);
                    end
                    if (stall) begin
                        // hold the entry and read it again next cycle
                        o_ram_raddr = r_base + psbf_pkg::t_addr'(r_q_s);
                    end else begin
                        if (emit) begin
                            if (r_h_vld) begin
                                o_push.valid = 1'b1;
                                o_push.res   = r_h;
                            end
                            n_h     = chunk;
                            n_h_vld = 1'b1;
                            n_n     = n_inc;
                        end
                        if (r_q_vld && entry.valid) begin
                            if (ovf && stop) begin
                                // result limit: entry stays buffered
                                n_ents  = 4'd0;
                                n_bytes = 8'd0;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = r_base + psbf_pkg::t_addr'(r_q_s);
                                if (full) begin
                                    n_ents  = 4'd0;
                                    n_bytes = 8'd0;
                                end else begin
                                    n_ents  = ents_a;
                                    n_bytes = bytes_a;
                                    n_first = first_a;
                                    n_final = r_q_s;
                                end
                            end
                        end
                        if (!stop && r_ptr < r_end) begin
                            n_q_vld = 1'b1;
                            n_q_s   = r_ptr[6:0];
                            n_ptr   = r_ptr + 8'd1;
                        end else begin
                            n_q_vld = 1'b0;
                            if (stop) begin
                                n_ptr = r_end;
                            end
                        end
                    end
                end else if (r_ents != 4'd0) begin
                    // flush the open chunk
                    if (!(r_h_vld && !i_out_free)) begin
                        if (r_h_vld) begin
                            o_push.valid = 1'b1;
                            o_push.res   = r_h;
                        end
                        n_h     = cur_chunk;
                        n_h_vld = 1'b1;
                        n_ents  = 4'd0;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_out_free) begin
                    o_push.valid = 1'b1;
                    if (r_h_vld) begin
                        o_push.res = r_h;
                    end else begin
                        o_push.res = '{status: psbf_pkg::STATUS_OK,
                                       chunk_first: r_start,
                                       chunk_final: 7'(r_end - 8'd1),
                                       chunk_entries: 4'd0,
                                       chunk_bytes: 8'd0, last: 1'b0};
                    end
                    o_push.res.last = 1'b1;
                    n_h_vld = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_start <= n_start;
        r_end   <= n_end;
        r_ptr   <= n_ptr;
        r_q_s   <= n_q_s;
        r_bytes <= n_bytes;
        r_first <= n_first;
        r_final <= n_final;
        r_h     <= n_h;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_q_vld <= 1'b0;
            r_ents  <= 4'd0;
            r_n     <= '0;
            r_h_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_q_vld <= n_q_vld;
            r_ents  <= n_ents;
            r_n     <= n_n;
            r_h_vld <= n_h_vld;
        end
    end

endmodule

### src/pawr_subevent_buffer_flush_core.sv
// pawr_subevent_buffer_flush_core: top level of the PAwR subevent buffer.
// Depends on psbf_pkg, psbf_if, psbf_ram, psbf_oreg and psbf_engine.
`timescale 1ns / 1ps

// PAwR subevent data buffer with window flush. One descriptor per handle and
// subevent (valid, first response slot, slot count, payload length) lives in
// a single synchronous RAM of HANDLES*SUBEVENTS words. A write word sets or
// clears one descriptor and returns one result. A request word scans the
// window [start, start+count) of one handle, one RAM entry per cycle while
// the result sink does not stall, packs the valid descriptors in subevent
// order into chunks of at most CHUNK_ENTRIES entries and CHUNK_BYTES bytes
// (4 + length each), emits one result per chunk, at most MAX_RESULTS, and
// clears what it emitted; an empty window gives one empty result, a bad word
// gives one status=1 result. After reset a clearing pass writes every RAM
// word, during which no input word is taken. A write or bad word goes from
// idle to done; a request goes from idle through the scan and a flush of the
// open chunk to done, and waits while the result sink stalls. One word is in
// work at a time; the finished result sits in an output register, so the
// next input word is taken while that result waits.
module pawr_subevent_buffer_flush_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psbf_in_if.sink    i_in,
    psbf_out_if.source o_out
);

    psbf_pkg::t_cmd                  cmd;
    logic                            take;
    logic                            eng_ready;
    logic                            out_free;
    psbf_pkg::t_push                 push;
    logic                            ram_we;
    psbf_pkg::t_addr                 ram_waddr;
    logic [psbf_pkg::ENTRY_W-1:0]    ram_wdata;
    psbf_pkg::t_addr                 ram_raddr;
    logic [psbf_pkg::ENTRY_W-1:0]    ram_rdata;

    logic [8:0] win_end;
    logic       bad_handle;
    logic       bad_write;
    logic       bad_req;

    assign i_in.ready = eng_ready;
    assign take       = i_in.valid && eng_ready;

    // input word decode: range checks and table addresses
    assign win_end    = {2'b00, i_in.subevent_index} + {1'b0, i_in.window_count};
    assign bad_handle = int'(i_in.handle) >= psbf_pkg::HANDLES;
    assign bad_write  = bad_handle
                     || (int'(i_in.subevent_index) >= psbf_pkg::SUBEVENTS)
                     || (i_in.payload_length > psbf_pkg::LEN_MAX);
    // zero count and windows running past the last subevent are flagged bad
    assign bad_req    = bad_handle
                     || (i_in.window_count == 8'd0)
                     || (int'(win_end) > psbf_pkg::SUBEVENTS);

    always_comb begin
        cmd.is_write = (i_in.mode == psbf_pkg::MODE_WRITE);
        cmd.bad      = cmd.is_write ? bad_write : bad_req;
        cmd.start    = i_in.subevent_index;
        cmd.wend     = win_end[7:0];
        cmd.base     = psbf_pkg::t_addr'(int'(i_in.handle) * psbf_pkg::SUBEVENTS);
        cmd.wr_addr  = cmd.base + psbf_pkg::t_addr'(i_in.subevent_index);
        // a zero length clears the descriptor
        if (i_in.payload_length == 8'd0) begin
            cmd.wr_entry = '0;
        end else begin
            cmd.wr_entry.valid      = 1'b1;
            cmd.wr_entry.slot_first = i_in.slot_first;
            cmd.wr_entry.slot_total = i_in.slot_total;
            cmd.wr_entry.length     = i_in.payload_length;
        end
    end

    psbf_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_cmd       (cmd),
        .o_ready     (eng_ready),
        .i_out_free  (out_free),
        .o_push      (push),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    psbf_ram #(
        .DEPTH (psbf_pkg::DEPTH),
        .WIDTH (psbf_pkg::ENTRY_W),
        .AW    (psbf_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    psbf_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule
